@@ rtl/rpwdr_pkg.sv @@
package rpwdr_pkg;

	// Default sizes of the frame store and of the panel coordinates.
	localparam int STORE_PIXELS_DEF = 524288;
	localparam int COORD_BITS_DEF = 11;

	// Depth of the queue between the front and the back end (power of two).
	localparam int QUEUE_DEPTH = 4;

	// Stream payload widths.
	localparam int IN_TDATA_BITS = 48;
	localparam int IN_TUSER_BITS = 2;
	localparam int OUT_BITS = 70;
	localparam int OUT_TDATA_BITS = 72;
	localparam int RECT_BITS = 11;
	localparam int WORD_BITS = 24;
	localparam int CFG_DATA_BITS = 12;
	localparam int CFG_INDEX_BITS = 3;

	// Item kinds.
	localparam logic [1:0] OP_DRAW = 2'd0;
	localparam logic [1:0] OP_FLUSH = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Rotations.
	localparam logic [1:0] ROT_0 = 2'd0;
	localparam logic [1:0] ROT_90 = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// Pixel formats.
	localparam logic [1:0] FMT_RGB888 = 2'd0;
	localparam logic [1:0] FMT_BGR888 = 2'd1;
	localparam logic [1:0] FMT_RGB565 = 2'd2;
	localparam logic [1:0] FMT_RGB332 = 2'd3;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_ROTATION = 3'd0;
	localparam logic [2:0] REG_PANEL_WIDTH = 3'd1;
	localparam logic [2:0] REG_PANEL_HEIGHT = 3'd2;
	localparam logic [2:0] REG_PIXEL_FORMAT = 3'd3;
	localparam logic [2:0] REG_CLIP_X_MIN = 3'd4;
	localparam logic [2:0] REG_CLIP_X_MAX = 3'd5;
	localparam logic [2:0] REG_CLIP_Y_MIN = 3'd6;
	localparam logic [2:0] REG_CLIP_Y_MAX = 3'd7;

	// Register reset values.
	localparam logic [1:0] ROTATION_RST = ROT_0;
	localparam logic [11:0] PANEL_WIDTH_RST = 12'd800;
	localparam logic [11:0] PANEL_HEIGHT_RST = 12'd480;
	localparam logic [1:0] PIXEL_FORMAT_RST = FMT_RGB888;
	localparam logic [10:0] CLIP_MIN_RST = 11'd0;
	localparam logic [10:0] CLIP_MAX_RST = 11'd2047;

	// RGB565 packing masks.
	localparam logic [7:0] MASK_565_HI = 8'hF8;
	localparam logic [7:0] MASK_565_LO = 8'h1C;

	// Classified item as it travels from the front to the back end.
	typedef struct packed {
		logic [1:0]           op;
		logic                 hit;       // point inside panel and store
		logic                 cmp_eq;    // skip the write if the word is unchanged
		logic                 no_store;  // grow the rectangle without a store write
		logic [WORD_BITS-1:0] word;
	} rpwdr_ctl_t;

endpackage

@@ rtl/rotated_pixel_writer_dirty_rect_unit.sv @@
// Framebuffer pixel writer. Each input item is a draw, a flush, a read or an
// unused code, chosen by s_axis_tuser, and gives exactly one result item. A draw
// is clipped against the logical window, rotated into panel coordinates, bounds
// checked, packed in the configured pixel format and written at y*width+x; the
// dirty rectangle grows to cover it. RGB332 grows it without a write; an
// unchanged RGB565 word does neither. A flush returns and empties the rectangle,
// a read returns a word. The front end takes one item per cycle while the queue
// has room, through a two-stage classify and address pipeline into a four-entry
// queue. The back end works on the single-port frame store, reads on a pop, then
// writes and responds in its execute state, and takes no new item until the last
// is done. After reset the store is cleared one word per cycle, all STORE_PIXELS
// words (524288 by default), with s_axis_tready held low; configuration writes
// are taken at any time but are meant to be made only while no item is in flight.
module rotated_pixel_writer_dirty_rect_unit
	import rpwdr_pkg::*;
#(
	parameter int STORE_PIXELS = STORE_PIXELS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// pos_x[11:0], pos_y[23:12], red[31:24], green[39:32], blue[47:40]
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
	// op[1:0]
	input  logic [IN_TUSER_BITS-1:0]  s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// pixel_written[0], dirty_valid[1], dirty_left[12:2], dirty_top[23:13],
	// dirty_right[34:24], dirty_bottom[45:35], read_word[69:46], zero[71:70]
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CB = COORD_BITS;
	localparam int AW = $clog2(STORE_PIXELS);
	localparam int QW = $bits(rpwdr_ctl_t) + AW + 2 * CB;

	logic [1:0] rotation_q;
	logic [11:0] panel_width_q;
	logic [11:0] panel_height_q;
	logic [1:0] pixel_format_q;
	logic [10:0] clip_x_min_q;
	logic [10:0] clip_x_max_q;
	logic [10:0] clip_y_min_q;
	logic [10:0] clip_y_max_q;

	logic run;
	logic [CB:0] eff_w;
	logic [CB:0] eff_h;
	logic fq_valid;
	logic fq_ready;
	rpwdr_ctl_t fq_ctl;
	logic [AW-1:0] fq_addr;
	logic [CB-1:0] fq_x;
	logic [CB-1:0] fq_y;
	logic bq_valid;
	logic bq_ready;
	logic [QW-1:0] bq_data;
	rpwdr_ctl_t bq_ctl;
	logic [AW-1:0] bq_addr;
	logic [CB-1:0] bq_x;
	logic [CB-1:0] bq_y;
	logic [OUT_BITS-1:0] out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= ROTATION_RST;
			panel_width_q <= PANEL_WIDTH_RST;
			panel_height_q <= PANEL_HEIGHT_RST;
			pixel_format_q <= PIXEL_FORMAT_RST;
			clip_x_min_q <= CLIP_MIN_RST;
			clip_x_max_q <= CLIP_MAX_RST;
			clip_y_min_q <= CLIP_MIN_RST;
			clip_y_max_q <= CLIP_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROTATION:     rotation_q <= cfg_data[1:0];
				REG_PANEL_WIDTH:  panel_width_q <= cfg_data;
				REG_PANEL_HEIGHT: panel_height_q <= cfg_data;
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_data[1:0];
				REG_CLIP_X_MIN:   clip_x_min_q <= cfg_data[10:0];
				REG_CLIP_X_MAX:   clip_x_max_q <= cfg_data[10:0];
				REG_CLIP_Y_MIN:   clip_y_min_q <= cfg_data[10:0];
				REG_CLIP_Y_MAX:   clip_y_max_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	rpwdr_front #(
		.STORE_PIXELS(STORE_PIXELS),
		.COORD_BITS  (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.run         (run),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_op       (s_axis_tuser[1:0]),
		.in_x        (s_axis_tdata[11:0]),
		.in_y        (s_axis_tdata[23:12]),
		.in_red      (s_axis_tdata[31:24]),
		.in_green    (s_axis_tdata[39:32]),
		.in_blue     (s_axis_tdata[47:40]),
		.rotation    (rotation_q),
		.panel_width (panel_width_q),
		.panel_height(panel_height_q),
		.pixel_format(pixel_format_q),
		.clip_x_min  (clip_x_min_q),
		.clip_x_max  (clip_x_max_q),
		.clip_y_min  (clip_y_min_q),
		.clip_y_max  (clip_y_max_q),
		.eff_w       (eff_w),
		.eff_h       (eff_h),
		.q_valid     (fq_valid),
		.q_ready     (fq_ready),
		.q_ctl       (fq_ctl),
		.q_addr      (fq_addr),
		.q_x         (fq_x),
		.q_y         (fq_y)
	);

	rpwdr_fifo #(
		.W(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data ({fq_ctl, fq_addr, fq_x, fq_y}),
		.pop_valid (bq_valid),
		.pop_ready (bq_ready),
		.pop_data  (bq_data)
	);

	assign {bq_ctl, bq_addr, bq_x, bq_y} = bq_data;

	rpwdr_back #(
		.STORE_PIXELS(STORE_PIXELS),
		.COORD_BITS  (COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.run      (run),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.q_valid  (bq_valid),
		.q_ready  (bq_ready),
		.q_ctl    (bq_ctl),
		.q_addr   (bq_addr),
		.q_x      (bq_x),
		.q_y      (bq_y),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (out_data)
	);

	assign m_axis_tdata = {(OUT_TDATA_BITS - OUT_BITS)'(0), out_data};

endmodule

@@ rtl/rpwdr_fifo.sv @@
module rpwdr_fifo
	import rpwdr_pkg::*;
#(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [W-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/rpwdr_front.sv @@
module rpwdr_front
	import rpwdr_pkg::*;
#(
	parameter int STORE_PIXELS = STORE_PIXELS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            run,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      in_op,
	input  logic signed [11:0]              in_x,
	input  logic signed [11:0]              in_y,
	input  logic [7:0]                      in_red,
	input  logic [7:0]                      in_green,
	input  logic [7:0]                      in_blue,
	input  logic [1:0]                      rotation,
	input  logic [11:0]                     panel_width,
	input  logic [11:0]                     panel_height,
	input  logic [1:0]                      pixel_format,
	input  logic [10:0]                     clip_x_min,
	input  logic [10:0]                     clip_x_max,
	input  logic [10:0]                     clip_y_min,
	input  logic [10:0]                     clip_y_max,
	output logic [COORD_BITS:0]             eff_w,
	output logic [COORD_BITS:0]             eff_h,
	output logic                            q_valid,
	input  logic                            q_ready,
	output rpwdr_ctl_t                      q_ctl,
	output logic [$clog2(STORE_PIXELS)-1:0] q_addr,
	output logic [COORD_BITS-1:0]           q_x,
	output logic [COORD_BITS-1:0]           q_y
);

	localparam int CB = COORD_BITS;
	localparam int SW = CB + 1;
	localparam int RW = (CB + 2 > 13) ? CB + 2 : 13;
	localparam int AFW = 2 * CB + 1;
	localparam int AW = $clog2(STORE_PIXELS);
	localparam int Lim = 1 << CB;
	localparam logic signed [RW-1:0] One = RW'(1);

	logic signed [RW-1:0] px;
	logic signed [RW-1:0] py;
	logic signed [RW-1:0] w_s;
	logic signed [RW-1:0] h_s;
	logic signed [RW-1:0] rx;
	logic signed [RW-1:0] ry;
	logic clip_ok;
	logic in_panel;
	logic point_ok;
	logic [7:0] hi565;
	logic [7:0] lo565;
	logic [WORD_BITS-1:0] word;
	logic adv_s1;
	logic adv_s2;
	logic take;

	logic vld_s1;
	rpwdr_ctl_t ctl_s1;
	logic [CB-1:0] x_s1;
	logic [CB-1:0] y_s1;
	logic vld_s2;
	rpwdr_ctl_t ctl_s2;
	logic [AFW-1:0] addr_s2;
	logic [CB-1:0] x_s2;
	logic [CB-1:0] y_s2;

	assign eff_w = ({1'b0, panel_width} > 13'(Lim)) ? SW'(Lim) : SW'(panel_width);
	assign eff_h = ({1'b0, panel_height} > 13'(Lim)) ? SW'(Lim) : SW'(panel_height);

	assign px = RW'(in_x);
	assign py = RW'(in_y);
	assign w_s = $signed(RW'(eff_w));
	assign h_s = $signed(RW'(eff_h));

	assign clip_ok = (px >= $signed(RW'(clip_x_min))) && (px <= $signed(RW'(clip_x_max))) &&
		(py >= $signed(RW'(clip_y_min))) && (py <= $signed(RW'(clip_y_max)));

	// A read addresses the panel directly; a draw is rotated first.
	always_comb begin
		rx = px;
		ry = py;
		if (in_op == OP_DRAW) begin
			case (rotation)
				ROT_90: begin
					rx = w_s - py - One;
					ry = px;
				end
				ROT_180: begin
					rx = w_s - px - One;
					ry = h_s - py - One;
				end
				ROT_270: begin
					rx = py;
					ry = h_s - px - One;
				end
				default: begin
					rx = px;
					ry = py;
				end
			endcase
		end
	end

	assign in_panel = (rx >= 0) && (rx < w_s) && (ry >= 0) && (ry < h_s);
	assign point_ok = in_panel && ((in_op == OP_READ) || ((in_op == OP_DRAW) && clip_ok));

	assign hi565 = (in_red & MASK_565_HI) | {5'b0, in_green[7:5]};
	assign lo565 = ((in_green & MASK_565_LO) << 3) | {3'b0, in_blue[7:3]};

	always_comb begin
		case (pixel_format)
			FMT_RGB888: word = {in_blue, in_green, in_red};
			FMT_BGR888: word = {in_red, in_green, in_blue};
			FMT_RGB565: word = {8'h00, hi565, lo565};
			default:    word = '0;
		endcase
	end

	assign adv_s2 = !vld_s2 || q_ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_ready = adv_s1 && run;
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= take;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ctl_s1.op <= in_op;
			ctl_s1.hit <= point_ok;
			ctl_s1.cmp_eq <= (pixel_format == FMT_RGB565);
			ctl_s1.no_store <= (pixel_format == FMT_RGB332);
			ctl_s1.word <= word;
			x_s1 <= rx[CB-1:0];
			y_s1 <= ry[CB-1:0];
		end
		if (adv_s2) begin
			ctl_s2 <= ctl_s1;
			addr_s2 <= AFW'(y_s1) * AFW'(eff_w) + AFW'(x_s1);
			x_s2 <= x_s1;
			y_s2 <= y_s1;
		end
	end

	// A point past the end of the store is dropped like one off the panel.
	always_comb begin
		q_ctl = ctl_s2;
		q_ctl.hit = ctl_s2.hit && (32'(addr_s2) < 32'(STORE_PIXELS));
	end

	assign q_valid = vld_s2;
	assign q_addr = AW'(addr_s2);
	assign q_x = x_s2;
	assign q_y = y_s2;

endmodule

@@ rtl/rpwdr_back.sv @@
module rpwdr_back
	import rpwdr_pkg::*;
#(
	parameter int STORE_PIXELS = STORE_PIXELS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	output logic                            run,
	input  logic [COORD_BITS:0]             eff_w,
	input  logic [COORD_BITS:0]             eff_h,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  rpwdr_ctl_t                      q_ctl,
	input  logic [$clog2(STORE_PIXELS)-1:0] q_addr,
	input  logic [COORD_BITS-1:0]           q_x,
	input  logic [COORD_BITS-1:0]           q_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [OUT_BITS-1:0]             out_data
);

	localparam int CB = COORD_BITS;
	localparam int SW = CB + 1;
	localparam int AW = $clog2(STORE_PIXELS);
	localparam int Lim = 1 << CB;
	localparam int XLoRst = (int'(PANEL_WIDTH_RST) > Lim) ? Lim : int'(PANEL_WIDTH_RST);
	localparam int YLoRst = (int'(PANEL_HEIGHT_RST) > Lim) ? Lim : int'(PANEL_HEIGHT_RST);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [AW-1:0] clr_q;
	logic [WORD_BITS-1:0] frame_store_q [STORE_PIXELS];
	logic [WORD_BITS-1:0] rdata_q;
	rpwdr_ctl_t ex_ctl_q;
	logic [AW-1:0] ex_addr_q;
	logic [CB-1:0] ex_x_q;
	logic [CB-1:0] ex_y_q;
	logic [SW-1:0] x_lo_q;
	logic [SW-1:0] y_lo_q;
	logic [CB-1:0] x_hi_q;
	logic [CB-1:0] y_hi_q;
	logic out_valid_q;
	logic [OUT_BITS-1:0] out_data_q;

	logic out_free;
	logic pop;
	logic exec;
	logic draw_ok;
	logic do_write;
	logic flush;
	logic rect_valid;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic res_pw;
	logic res_dv;
	logic [RECT_BITS-1:0] res_left;
	logic [RECT_BITS-1:0] res_top;
	logic [RECT_BITS-1:0] res_right;
	logic [RECT_BITS-1:0] res_bottom;
	logic [WORD_BITS-1:0] res_word;

	assign run = (state_q != ST_CLEAR);
	assign out_free = !out_valid_q || out_ready;
	assign pop = (state_q == ST_IDLE) && q_valid && out_free;
	assign q_ready = pop;
	assign exec = (state_q == ST_EXEC);

	// An RGB565 draw of the value already stored changes nothing.
	assign draw_ok = exec && (ex_ctl_q.op == OP_DRAW) && ex_ctl_q.hit &&
		!(ex_ctl_q.cmp_eq && (rdata_q == ex_ctl_q.word));
	assign do_write = draw_ok && !ex_ctl_q.no_store;
	assign flush = exec && (ex_ctl_q.op == OP_FLUSH);
	assign rect_valid = (x_lo_q <= {1'b0, x_hi_q}) && (y_lo_q <= {1'b0, y_hi_q});

	assign mem_we = (state_q == ST_CLEAR) || do_write;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : ex_ctl_q.word;

	always_comb begin
		case (state_q)
			ST_CLEAR: mem_addr = clr_q;
			ST_IDLE:  mem_addr = q_addr;
			default:  mem_addr = ex_addr_q;
		endcase
	end

	// Single-port store: the read for an item happens on its pop, the write in the next cycle, in the execute state.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_store_q[mem_addr] <= mem_wdata;
		end else begin
			rdata_q <= frame_store_q[mem_addr];
		end
	end

	always_comb begin
		res_pw = draw_ok;
		res_dv = flush && rect_valid;
		res_left = res_dv ? RECT_BITS'(x_lo_q) : '0;
		res_top = res_dv ? RECT_BITS'(y_lo_q) : '0;
		res_right = res_dv ? RECT_BITS'(x_hi_q) : '0;
		res_bottom = res_dv ? RECT_BITS'(y_hi_q) : '0;
		res_word = ((ex_ctl_q.op == OP_READ) && ex_ctl_q.hit) ? rdata_q : '0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ex_ctl_q <= q_ctl;
			ex_addr_q <= q_addr;
			ex_x_q <= q_x;
			ex_y_q <= q_y;
		end
		if (exec) begin
			out_data_q <= {res_word, res_bottom, res_right, res_top, res_left, res_dv, res_pw};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			x_lo_q <= SW'(XLoRst);
			y_lo_q <= SW'(YLoRst);
			x_hi_q <= '0;
			y_hi_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(STORE_PIXELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (flush) begin
				x_lo_q <= eff_w;
				y_lo_q <= eff_h;
				x_hi_q <= '0;
				y_hi_q <= '0;
			end else if (draw_ok) begin
				if ({1'b0, ex_x_q} < x_lo_q) begin
					x_lo_q <= {1'b0, ex_x_q};
				end
				if ({1'b0, ex_y_q} < y_lo_q) begin
					y_lo_q <= {1'b0, ex_y_q};
				end
				if (ex_x_q > x_hi_q) begin
					x_hi_q <= ex_x_q;
				end
				if (ex_y_q > y_hi_q) begin
					y_hi_q <= ex_y_q;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

@@ rtl/rpwdr_checker.sv @@
module rpwdr_checker
	import rpwdr_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// A draw that wrote reports nothing else.
	a_draw_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tdata[OUT_TDATA_BITS-1:1] == '0))
		else $error("draw result carries other fields");

	// Without a valid rectangle all rectangle fields are zero.
	a_rect_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[1] |-> (m_axis_tdata[45:2] == '0))
		else $error("rectangle fields set without a valid rectangle");

	// A reported rectangle is ordered and comes without a read word.
	a_rect_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |->
			(m_axis_tdata[12:2] <= m_axis_tdata[34:24]) &&
			(m_axis_tdata[23:13] <= m_axis_tdata[45:35]) &&
			(m_axis_tdata[71:46] == '0))
		else $error("flush reported a malformed rectangle");

endmodule

bind rotated_pixel_writer_dirty_rect_unit rpwdr_checker u_rpwdr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

@@ sim/rpwdr_checker.sv @@
module rpwdr_tb_checker
	import rpwdr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	// pos_x[11:0], pos_y[23:12], red[31:24], green[39:32], blue[47:40]
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
	// op[1:0]
	input  logic [IN_TUSER_BITS-1:0]  s_axis_tuser,
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// pixel_written[0], dirty_valid[1], dirty_left[12:2], dirty_top[23:13],
	// dirty_right[34:24], dirty_bottom[45:35], read_word[69:46], zero[71:70]
	input  logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        outstanding,
	output int                        fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        written;
		logic        rect_valid;
		logic [10:0] left;
		logic [10:0] top;
		logic [10:0] right;
		logic [10:0] bottom;
		logic [23:0] word;
		logic [1:0]  pad;
	} response_t;

	logic [1:0]  rotation_q;
	logic [11:0] width_q;
	logic [11:0] height_q;
	logic [1:0]  format_q;
	logic [10:0] clip_x_lo_q;
	logic [10:0] clip_x_hi_q;
	logic [10:0] clip_y_lo_q;
	logic [10:0] clip_y_hi_q;

	int rect_x_lo;
	int rect_y_lo;
	int rect_x_hi;
	int rect_y_hi;

	// Words never written read as zero, which matches the cleared store.
	logic [23:0] frame_words [int];
	response_t   awaited_responses [$];
	int          result_index;

	function automatic int clamp_size(logic [11:0] s);
		return (int'(s) > (1 << COORD_BITS_DEF)) ? (1 << COORD_BITS_DEF) : int'(s);
	endfunction

	function automatic void empty_rect();
		rect_x_lo = clamp_size(width_q);
		rect_y_lo = clamp_size(height_q);
		rect_x_hi = 0;
		rect_y_hi = 0;
	endfunction

	function automatic logic [23:0] stored_word(int addr);
		return frame_words.exists(addr) ? frame_words[addr] : 24'h000000;
	endfunction

	function automatic logic draw_pixel(int x, int y, logic [7:0] r, logic [7:0] g,
		logic [7:0] b);
		int w;
		int h;
		int t;
		int addr;
		logic [7:0] hi;
		logic [7:0] lo;
		w = clamp_size(width_q);
		h = clamp_size(height_q);
		if (x < int'(clip_x_lo_q) || x > int'(clip_x_hi_q) ||
			y < int'(clip_y_lo_q) || y > int'(clip_y_hi_q))
			return 1'b0;
		case (rotation_q)
		ROT_90: begin
			t = x;
			x = w - y - 1;
			y = t;
		end
		ROT_180: begin
			x = w - x - 1;
			y = h - y - 1;
		end
		ROT_270: begin
			t = x;
			x = y;
			y = h - t - 1;
		end
		default: ;
		endcase
		if (x < 0 || x >= w || y < 0 || y >= h)
			return 1'b0;
		addr = y * w + x;
		if (addr >= STORE_PIXELS_DEF)
			return 1'b0;
		case (format_q)
		FMT_RGB888: frame_words[addr] = {b, g, r};
		FMT_BGR888: frame_words[addr] = {r, g, b};
		FMT_RGB565: begin
			hi = (r & MASK_565_HI) | {5'b00000, g[7:5]};
			lo = ((g & MASK_565_LO) << 3) | {3'b000, b[7:3]};
			// Rewriting the same 565 value leaves store and rectangle untouched.
			if (stored_word(addr) == {8'h00, hi, lo})
				return 1'b0;
			frame_words[addr] = {8'h00, hi, lo};
		end
		default: ;
		endcase
		if (x < rect_x_lo) rect_x_lo = x;
		if (y < rect_y_lo) rect_y_lo = y;
		if (x > rect_x_hi) rect_x_hi = x;
		if (y > rect_y_hi) rect_y_hi = y;
		return 1'b1;
	endfunction

	function automatic response_t compute_response(logic [1:0] op,
		logic [IN_TDATA_BITS-1:0] data);
		response_t resp;
		int x;
		int y;
		int w;
		int h;
		int addr;
		resp = '{default: '0};
		x = int'($signed(data[11:0]));
		y = int'($signed(data[23:12]));
		case (op)
		OP_DRAW: resp.written = draw_pixel(x, y, data[31:24], data[39:32], data[47:40]);
		OP_FLUSH: begin
			if (rect_x_lo <= rect_x_hi && rect_y_lo <= rect_y_hi) begin
				resp.rect_valid = 1'b1;
				resp.left = 11'(rect_x_lo);
				resp.top = 11'(rect_y_lo);
				resp.right = 11'(rect_x_hi);
				resp.bottom = 11'(rect_y_hi);
			end
			empty_rect();
		end
		OP_READ: begin
			w = clamp_size(width_q);
			h = clamp_size(height_q);
			if (x >= 0 && x < w && y >= 0 && y < h) begin
				addr = y * w + x;
				if (addr < STORE_PIXELS_DEF)
					resp.word = stored_word(addr);
			end
		end
		default: ;
		endcase
		return resp;
	endfunction

	task automatic log_mismatch(string what);
		$display("%0t ns: result %0d: %s", $time, result_index, what);
		fail_count++;
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen)
			log_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, seen));
	endtask

	task automatic check_response(response_t want, logic [OUT_TDATA_BITS-1:0] seen);
		compare_field("pixel_written", 32'(want.written), 32'(seen[0]));
		compare_field("dirty_valid", 32'(want.rect_valid), 32'(seen[1]));
		compare_field("dirty_left", 32'(want.left), 32'(seen[12:2]));
		compare_field("dirty_top", 32'(want.top), 32'(seen[23:13]));
		compare_field("dirty_right", 32'(want.right), 32'(seen[34:24]));
		compare_field("dirty_bottom", 32'(want.bottom), 32'(seen[45:35]));
		compare_field("read_word", 32'(want.word), 32'(seen[69:46]));
		compare_field("padding", 32'(want.pad), 32'(seen[71:70]));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q = ROTATION_RST;
			width_q = PANEL_WIDTH_RST;
			height_q = PANEL_HEIGHT_RST;
			format_q = PIXEL_FORMAT_RST;
			clip_x_lo_q = CLIP_MIN_RST;
			clip_x_hi_q = CLIP_MAX_RST;
			clip_y_lo_q = CLIP_MIN_RST;
			clip_y_hi_q = CLIP_MAX_RST;
			empty_rect();
			frame_words.delete();
			awaited_responses.delete();
			result_index = 0;
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_ROTATION: rotation_q = cfg_data[1:0];
				REG_PANEL_WIDTH: width_q = cfg_data[11:0];
				REG_PANEL_HEIGHT: height_q = cfg_data[11:0];
				REG_PIXEL_FORMAT: format_q = cfg_data[1:0];
				REG_CLIP_X_MIN: clip_x_lo_q = cfg_data[10:0];
				REG_CLIP_X_MAX: clip_x_hi_q = cfg_data[10:0];
				REG_CLIP_Y_MIN: clip_y_lo_q = cfg_data[10:0];
				default: clip_y_hi_q = cfg_data[10:0];
				endcase
			end
			// Results are checked before new items are queued, so a result can
			// never be matched against an item accepted at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_responses.size() == 0)
					log_mismatch("result item arrived with none expected");
				else
					check_response(awaited_responses.pop_front(), m_axis_tdata);
				result_index++;
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_responses.push_back(compute_response(s_axis_tuser, s_axis_tdata));
			outstanding <= awaited_responses.size();
		end
	end

endmodule

@@ sim/tb_rotated_pixel_writer_dirty_rect_unit.sv @@
module tb_rotated_pixel_writer_dirty_rect_unit
	import rpwdr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_MOSTLY,
		READY_RARELY,
		READY_PERIODIC
	} drain_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_BITS-1:0]  s_axis_tuser = OP_DRAW;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_ROTATION;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	int results_pending;
	int mismatches;

	// Shaping of the random items for the current settings.
	int          burst_left = 0;
	int          panel_w;
	int          panel_h;
	int          span_x;
	int          span_y;
	int          anchor_x;
	int          anchor_y;
	logic [23:0] palette [4];

	drain_mode_t drain_mode = READY_ALWAYS;
	int          drain_left = 0;
	logic [2:0]  drain_tick = '0;

	rotated_pixel_writer_dirty_rect_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rpwdr_tb_checker u_tb_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(results_pending),
		.fail_count(mismatches)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// The receiver switches at random between four ready patterns.
	always @(posedge clk) begin
		drain_tick <= drain_tick + 3'd1;
		if (drain_left == 0) begin
			drain_mode <= drain_mode_t'($urandom_range(0, 3));
			drain_left <= $urandom_range(16, 96);
		end else begin
			drain_left <= drain_left - 1;
		end
		case (drain_mode)
		READY_ALWAYS: m_axis_tready <= 1'b1;
		READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
		READY_RARELY: m_axis_tready <= ($urandom_range(0, 3) == 0);
		default: m_axis_tready <= (drain_tick < 3'd5);
		endcase
	end

	// The colour is packed as {blue, green, red}, matching the upper tdata bytes.
	task automatic send_item(input logic [1:0] op, input int x, input int y,
		input logic [23:0] colour);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {colour, 12'(y), 12'(x)};
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input int value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= 12'(value);
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [1:0] rot, input int w, input int h,
		input logic [1:0] fmt, input int cx0, input int cx1, input int cy0, input int cy1);
		wait_idle();
		write_reg(REG_ROTATION, rot);
		write_reg(REG_PANEL_WIDTH, w);
		write_reg(REG_PANEL_HEIGHT, h);
		write_reg(REG_PIXEL_FORMAT, fmt);
		write_reg(REG_CLIP_X_MIN, cx0);
		write_reg(REG_CLIP_X_MAX, cx1);
		write_reg(REG_CLIP_Y_MIN, cy0);
		write_reg(REG_CLIP_Y_MAX, cy1);
		cfg_we <= 1'b0;
		panel_w = (w > 2048) ? 2048 : w;
		panel_h = (h > 2048) ? 2048 : h;
		// Logical extents swap under a quarter turn.
		if (rot == ROT_90 || rot == ROT_270) begin
			span_x = panel_h;
			span_y = panel_w;
		end else begin
			span_x = panel_w;
			span_y = panel_h;
		end
		anchor_x = (span_x > 8) ? $urandom_range(0, span_x - 8) : 0;
		anchor_y = (span_y > 8) ? $urandom_range(0, span_y - 8) : 0;
		foreach (palette[i])
			palette[i] = 24'($urandom);
		burst_left = 0;
	endtask

	// Mostly points on or just around the panel, a share clustered in a small
	// window so that large panels still see repeated draws and reads.
	function automatic int pick_coord(int span, int anchor);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return int'($urandom_range(0, 4095)) - 2048;
		if (roll < 45)
			return anchor + int'($urandom_range(0, 7));
		return int'($urandom_range(0, span + 1)) - 1;
	endfunction

	function automatic int random_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return $urandom_range(1, 40);
		if (roll < 94)
			return $urandom_range(41, 4095);
		return 0;
	endfunction

	task automatic send_random(input int count);
		int roll;
		logic [23:0] colour;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			colour = $urandom_range(0, 1) ? palette[$urandom_range(0, 3)] : 24'($urandom);
			if (roll < 65)
				send_item(OP_DRAW, pick_coord(span_x, anchor_x),
					pick_coord(span_y, anchor_y), colour);
			else if (roll < 75)
				send_item(OP_FLUSH, $urandom_range(0, 4095), $urandom_range(0, 4095), colour);
			else if (roll < 96)
				send_item(OP_READ, pick_coord(panel_w, anchor_x),
					pick_coord(panel_h, anchor_y), colour);
			else
				send_item(OP_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095), colour);
		end
	endtask

	initial begin
		int cx0;
		int cx1;
		int cy0;
		int cy1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: 800 x 480, no rotation, RGB888, clip window open.
		send_item(OP_DRAW, 0, 0, 24'hFFFFFF);
		send_item(OP_DRAW, 799, 479, 24'h0180AA);
		send_item(OP_DRAW, 800, 0, 24'h123456);
		send_item(OP_DRAW, -1, 0, 24'hFFFFFF);
		send_item(OP_DRAW, -2048, -2048, 24'h000000);
		send_item(OP_DRAW, 2047, 2047, 24'hFFFFFF);
		send_item(OP_READ, 0, 0, 24'h000000);
		send_item(OP_READ, 799, 479, 24'h000000);
		send_item(OP_READ, 800, 0, 24'h000000);
		send_item(OP_READ, -1, -1, 24'hFFFFFF);
		send_item(OP_READ, 2047, 2047, 24'h000000);
		send_item(OP_FLUSH, 0, 0, 24'h000000);
		send_item(OP_FLUSH, 0, 0, 24'h000000);
		send_item(OP_UNUSED, 5, 5, 24'hA5A5A5);

		apply_settings(ROT_90, 16, 12, FMT_RGB565, 0, 2047, 0, 2047);
		send_random(80);
		apply_settings(ROT_180, 20, 9, FMT_RGB332, 2, 15, 1, 7);
		send_random(80);
		apply_settings(ROT_270, 7, 30, FMT_BGR888, 0, 2047, 0, 2047);
		send_random(80);

		// A single-pixel panel in RGB565: the second identical write is skipped.
		apply_settings(ROT_0, 1, 1, FMT_RGB565, 0, 2047, 0, 2047);
		send_item(OP_DRAW, 0, 0, 24'h3CA4F8);
		send_item(OP_DRAW, 0, 0, 24'h3CA4F8);
		send_item(OP_READ, 0, 0, 24'h000000);
		send_item(OP_DRAW, 0, 0, 24'h071B00);
		send_item(OP_FLUSH, 0, 0, 24'h000000);
		send_random(80);

		// Oversized panel is taken as 2048 x 2048, so deep rows miss the store.
		apply_settings(ROT_90, 4095, 4095, FMT_RGB888, 0, 2047, 0, 2047);
		send_item(OP_DRAW, 300, 100, 24'h00FF00);
		send_item(OP_READ, 5, 400, 24'h000000);
		send_random(80);

		apply_settings(ROT_180, 0, 0, FMT_BGR888, 0, 2047, 0, 2047);
		send_random(80);

		// Clip window narrowed to the single logical point (2047, 0).
		apply_settings(ROT_0, 2048, 2048, FMT_RGB565, 2047, 2047, 0, 0);
		send_item(OP_DRAW, 2047, 0, 24'hFF00FF);
		send_item(OP_FLUSH, 0, 0, 24'h000000);
		send_random(80);

		apply_settings(ROT_270, 24, 24, FMT_BGR888, 10, 3, 2047, 5);
		send_random(80);

		for (int ph = 0; ph < 16; ph++) begin
			if ($urandom_range(0, 9) < 7) begin
				cx0 = 0;
				cx1 = 2047;
				cy0 = 0;
				cy1 = 2047;
			end else begin
				cx0 = $urandom_range(0, 30);
				cx1 = $urandom_range(0, 60);
				cy0 = $urandom_range(0, 30);
				cy1 = $urandom_range(0, 60);
			end
			apply_settings(2'($urandom_range(0, 3)), random_size(), random_size(),
				2'($urandom_range(0, 3)), cx0, cx1, cy0, cy1);
			send_random(80);
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("PASS rotated_pixel_writer_dirty_rect_unit");
		end else begin
			$display("FAIL rotated_pixel_writer_dirty_rect_unit");
		end
		$finish;
	end

	// The store clear after reset alone takes about 2.1 ms.
	initial begin
		#(8_000_000);
		$display("FAIL rotated_pixel_writer_dirty_rect_unit");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/rpwdr_pkg.sv
rtl/rpwdr_fifo.sv
rtl/rpwdr_front.sv
rtl/rpwdr_back.sv
rtl/rotated_pixel_writer_dirty_rect_unit.sv
rtl/rpwdr_checker.sv
sim/rpwdr_checker.sv
sim/tb_rotated_pixel_writer_dirty_rect_unit.sv
